// ----- rtl/padf_pkg.sv -----
// Shared types, constants and key normalisation for the per-array distinct filter.
`timescale 1ns / 1ps
package padf_pkg;
    localparam int SET_DEPTH = 256;
    localparam int IDX_W     = $clog2(SET_DEPTH);
    localparam int CNT_W     = IDX_W + 1;

    localparam logic [1:0] KIND_INT = 2'd0;
    localparam logic [1:0] KIND_F32 = 2'd1;
    localparam logic [1:0] KIND_F64 = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PROBE = 5'b00010,
        ST_DONE  = 5'b00100,
        ST_OUT   = 5'b01000,
        ST_CLEAR = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic probe;
        logic finish;
        logic clear_row;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic scan_end;
        logic is_empty;
        logic is_null;
        logic last;
    } t_status;

    function automatic logic [63:0] norm_key(input logic [1:0] kind, input logic [63:0] v);
        logic [63:0] r;
        r = v;
        if (kind == KIND_F32) begin
            r = {32'd0, v[31:0]};
            if (v[30:23] == 8'hFF && v[22:0] != 23'd0) r = 64'h7FC0_0000;
            else if (v[31:0] == 32'h8000_0000) r = 64'd0;
        end else if (kind == KIND_F64) begin
            if (v[62:52] == 11'h7FF && v[51:0] != 52'd0) r = 64'h7FF8_0000_0000_0000;
            else if (v == 64'h8000_0000_0000_0000) r = 64'd0;
        end
        return r;
    endfunction
endpackage

// ----- rtl/per_array_distinct_filter_core.sv -----
// Top level of the per-array distinct filter.
`timescale 1ns / 1ps
// Marks each array element kept when it is the first of its value in its array; nulls are
// kept once per array, float modes match all NaNs and +0/-0. One word in, one word out.
// An element's probe covers the entries already stored for the array (up to 256), since
// the set memory is probed one entry a cycle through its single read port; a hit ends
// the probe early, and a null or an empty-array word skips the probe. A word closing an
// array also passes through the row-clear state, and output stalls hold each word in the
// output state. Set of 256 entries.
module per_array_distinct_filter_core
    import padf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_elem_value,
    input  logic        i_elem_is_null,
    input  logic [30:0] i_elem_position,
    input  logic        i_row_empty,
    input  logic        i_last_in_row,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_keep,
    output logic [30:0] o_out_position,
    output logic        o_row_done,
    output logic [15:0] o_row_length,
    output logic        o_set_overflow
);
    logic [1:0] r_kind;
    t_cmd    cmd;
    t_status status;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {30'd0, r_kind} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_kind <= KIND_INT;
        else if (psel && penable && pwrite && paddr == 2'd0) r_kind <= pwdata[1:0];
    end

    padf_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_out_stall(i_stall), .i_status(status),
        .o_stall, .o_valid, .o_cmd(cmd)
    );

    padf_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_kind(r_kind), .i_elem_value, .i_elem_is_null,
        .i_elem_position, .i_row_empty, .i_last_in_row, .o_status(status), .o_keep,
        .o_out_position, .o_row_done, .o_row_length, .o_set_overflow
    );
endmodule

// ----- rtl/padf_ctrl.sv -----
// Controller state machine of the per-array distinct filter.
`timescale 1ns / 1ps
module padf_ctrl
    import padf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output logic    o_stall,
    output logic    o_valid,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (i_status.is_empty || i_status.is_null) n_state = ST_DONE;
                else begin
                    o_cmd.probe = 1'b1;
                    if (i_status.hit || i_status.scan_end) n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    if (i_status.last || i_status.is_empty) n_state = ST_CLEAR;
                    else n_state = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                o_cmd.clear_row = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_out_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_valid) else $error("valid while idle");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_out_stall) |=> o_valid) else $error("result dropped");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_stall) else $error("load while busy");
`endif
endmodule

// ----- rtl/padf_datapath.sv -----
// Datapath: key register, set memory, probe counter and row counters.
`timescale 1ns / 1ps
module padf_datapath
    import padf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_elem_value,
    input  logic        i_elem_is_null,
    input  logic [30:0] i_elem_position,
    input  logic        i_row_empty,
    input  logic        i_last_in_row,
    output t_status     o_status,
    output logic        o_keep,
    output logic [30:0] o_out_position,
    output logic        o_row_done,
    output logic [15:0] o_row_length,
    output logic        o_set_overflow
);
    logic [63:0] r_mem [SET_DEPTH];
    logic [63:0] r_rd;
    logic [63:0] r_key;
    logic        r_null, r_empty, r_last, r_null_seen, r_hit;
    logic [30:0] r_pos;
    logic [CNT_W-1:0] r_used, r_scan;
    logic [15:0] r_kept;
    logic        r_rd_ok;
    logic        keep_now, ovf_now, full;

    assign full = (r_used == CNT_W'(SET_DEPTH));
    // r_rd holds the entry at r_scan-1 when r_rd_ok
    assign o_status.hit      = r_rd_ok && (r_rd == r_key);
    assign o_status.scan_end = (r_scan == r_used) && !(r_rd_ok && r_rd == r_key);
    assign o_status.is_empty = r_empty;
    assign o_status.is_null  = r_null;
    assign o_status.last     = r_last;

    always_comb begin
        keep_now = 1'b0;
        ovf_now  = 1'b0;
        if (!r_empty) begin
            if (r_null) keep_now = !r_null_seen;
            else begin
                keep_now = !r_hit;
                ovf_now  = !r_hit && full;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= norm_key(i_kind, i_elem_value);
            r_null  <= i_elem_is_null;
            r_empty <= i_row_empty;
            r_last  <= i_last_in_row;
            r_pos   <= i_row_empty ? 31'd0 : i_elem_position;
        end
        if (i_cmd.probe && r_scan != r_used)
            r_rd <= r_mem[r_scan[IDX_W-1:0]];
        if (i_cmd.finish && !r_empty && !r_null && !r_hit && !full)
            r_mem[r_used[IDX_W-1:0]] <= r_key;
        if (i_cmd.finish) begin
            o_keep         <= keep_now;
            o_out_position <= r_pos;
            o_row_done     <= r_empty || r_last;
            o_set_overflow <= ovf_now;
            o_row_length   <= (keep_now && r_kept != 16'hFFFF) ? r_kept + 16'd1 : r_kept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0; r_scan <= '0; r_kept <= '0;
            r_null_seen <= 1'b0; r_hit <= 1'b0; r_rd_ok <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_scan <= '0; r_hit <= 1'b0; r_rd_ok <= 1'b0;
            end
            if (i_cmd.probe) begin
                if (o_status.hit) r_hit <= 1'b1;
                r_rd_ok <= (r_scan != r_used);
                if (r_scan != r_used) r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.finish && !r_empty) begin
                if (r_null) r_null_seen <= 1'b1;
                else if (!r_hit && !full) r_used <= r_used + 1'b1;
                if (keep_now && r_kept != 16'hFFFF) r_kept <= r_kept + 16'd1;
            end
            if (i_cmd.clear_row) begin
                r_used <= '0; r_scan <= '0; r_kept <= '0; r_null_seen <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(SET_DEPTH)) else $error("fill count beyond depth");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= r_used) else $error("probe beyond fill");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_row |=> (r_used == '0 && r_kept == 16'd0)) else $error("row not cleared");
`endif
endmodule

// ----- tb/per_array_distinct_filter_core_test.sv -----
// Self-checking testbench for the per-array distinct filter: directed table, then random arrays.
`timescale 1ns / 1ps
module per_array_distinct_filter_core_test;
    import padf_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic        is_null;
        logic [30:0] position;
        logic        empty;
        logic        last;
    } t_elem;

    typedef struct packed {
        logic        keep;
        logic [30:0] position;
        logic        done;
        logic [15:0] length;
        logic        overflow;
    } t_verdict;

    typedef struct {
        t_elem    e;
        logic     chk;
        t_verdict v;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 0;
    logic        o_stall;
    logic [63:0] i_elem_value = '0;
    logic        i_elem_is_null = 0;
    logic [30:0] i_elem_position = '0;
    logic        i_row_empty = 0;
    logic        i_last_in_row = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic        o_keep;
    logic [30:0] o_out_position;
    logic        o_row_done;
    logic [15:0] o_row_length;
    logic        o_set_overflow;

    per_array_distinct_filter_core uut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [1:0]  kind_m;
    logic [63:0] seen_keys[$];
    logic        null_m;
    logic [15:0] kept_m;

    t_verdict    pending[$];
    int          errors = 0;
    int          results = 0;
    int          overflows = 0;
    int          idle_cycles = 0;
    bit          quiet = 0;
    bit          hold_off = 0;
    bit          finished = 0;

    function automatic logic [63:0] canon(logic [1:0] k, logic [63:0] v);
        logic [63:0] r;
        r = v;
        if (k == KIND_F32) begin
            r = {32'd0, v[31:0]};
            if (v[30:23] == 8'hFF && v[22:0] != 0) r = 64'h7FC0_0000;
            else if (v[31:0] == 32'h8000_0000) r = 0;
        end else if (k == KIND_F64) begin
            if (v[62:52] == 11'h7FF && v[51:0] != 0) r = 64'h7FF8_0000_0000_0000;
            else if (v == 64'h8000_0000_0000_0000) r = 0;
        end
        return r;
    endfunction

    function automatic t_verdict filter_elem(t_elem e);
        t_verdict    r;
        logic [63:0] k;
        bit          hit;
        r = '0;
        if (e.empty) begin
            r.done = 1;
            r.length = kept_m;
        end else begin
            if (e.is_null) begin
                r.keep = !null_m;
                null_m = 1;
            end else begin
                k = canon(kind_m, e.value);
                hit = 0;
                foreach (seen_keys[i]) if (seen_keys[i] == k) hit = 1;
                if (!hit) begin
                    r.keep = 1;
                    if (seen_keys.size() < SET_DEPTH) seen_keys.push_back(k);
                    else r.overflow = 1;
                end
            end
            if (r.keep && kept_m != 16'hFFFF) kept_m++;
            r.position = e.position;
            r.done = e.last;
            r.length = kept_m;
        end
        if (r.done) begin
            seen_keys.delete();
            null_m = 0;
            kept_m = 0;
        end
        return r;
    endfunction

    task automatic write_kind(logic [1:0] k);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= 0; pwdata <= {30'd0, k};
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        kind_m = k;
    endtask

    // drive a word and hold until accepted; sender idles at random
    task automatic send_word(t_elem e, logic chk, t_verdict want);
        t_verdict p;
        while (!quiet && $urandom_range(99) < 21) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        {i_elem_value, i_elem_is_null, i_elem_position, i_row_empty, i_last_in_row} <= e;
        p = filter_elem(e);
        if (chk && p != want) begin
            $display("%0t table row disagrees with predictor: %h vs %h", $time, want, p);
            errors++;
        end
        pending.push_back(p);
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    function automatic t_elem rnd_elem(logic [1:0] k, int pool, bit last);
        t_elem e;
        e.value = {$urandom, $urandom};
        case ($urandom_range(7))
            0: e.value = 64'($urandom_range(pool));
            1: e.value = 64'h8000_0000_0000_0000;
            2: e.value = (k == KIND_F32) ? {e.value[63:32], 1'b0, 8'hFF, e.value[22:0] | 23'd1}
                                          : {1'b0, 11'h7FF, e.value[51:0] | 52'd1};
            3: e.value = {32'd0, 32'h8000_0000};
            4: e.value = 64'd0;
            default: e.value = {e.value[63:8], 8'(
                $urandom_range(pool))} & (($urandom_range(1)) ? 64'hFF : '1);
        endcase
        e.is_null = ($urandom_range(9) == 0);
        e.position = 31'($urandom >> 1);
        e.empty = 0;
        e.last = last;
        return e;
    endfunction

    t_row table_rows[$];

    function automatic t_elem mk(logic [63:0] v, logic n, logic [30:0] p, logic em, logic l);
        t_elem e;
        e = {v, n, p, em, l};
        return e;
    endfunction

    task automatic add_row(t_elem e, logic c = 0, t_verdict v = '0);
        t_row r;
        r.e = e; r.chk = c; r.v = v;
        table_rows.push_back(r);
    endtask

    // receiver
    always @(negedge i_clk) begin
        if (!finished) i_stall <= hold_off || (!quiet && $urandom_range(99) < 21);
    end

    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n && (i_valid && !o_stall || o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_keep, o_out_position, o_row_done, o_row_length, o_set_overflow};
            results++;
            if (o_set_overflow) overflows++;
            if (pending.size() == 0) begin
                $display("%0t unexpected word %h", $time, got);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got != want) begin
                    $display("%0t mismatch: expected keep=%b pos=%h done=%b len=%0d ovf=%b",
                             $time, want.keep, want.position, want.done, want.length,
                             want.overflow);
                    $display("%0t           actual   keep=%b pos=%h done=%b len=%0d ovf=%b",
                             $time, got.keep, got.position, got.done, got.length, got.overflow);
                    errors++;
                end
            end
        end
    end

    initial begin
        int n, len;
        logic [1:0] k;
        kind_m = KIND_INT;
        null_m = 0;
        kept_m = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        repeat (2) @(negedge i_clk);

        // directed: after reset, extremes, nulls, empty arrays
        add_row(mk(0, 0, 0, 1, 0), 1, {1'b0, 31'd0, 1'b1, 16'd0, 1'b0});
        add_row(mk('1, 0, '1, 0, 0), 1, {1'b1, 31'h7FFF_FFFF, 1'b0, 16'd1, 1'b0});
        add_row(mk('1, 0, 5, 0, 0), 1, {1'b0, 31'd5, 1'b0, 16'd1, 1'b0});
        add_row(mk(0, 1, 6, 0, 0), 1, {1'b1, 31'd6, 1'b0, 16'd2, 1'b0});
        add_row(mk('1, 1, 7, 0, 0), 1, {1'b0, 31'd7, 1'b0, 16'd2, 1'b0});
        add_row(mk(64'h8000_0000_0000_0000, 0, 8, 0, 0));
        add_row(mk(0, 0, 9, 0, 1));
        add_row(mk(5, 1, 1, 1, 1), 1, {1'b0, 31'd0, 1'b1, 16'd0, 1'b0});
        add_row(mk(0, 0, 0, 0, 1), 1, {1'b1, 31'd0, 1'b1, 16'd1, 1'b0});
        foreach (table_rows[i]) send_word(table_rows[i].e, table_rows[i].chk, table_rows[i].v);
        drain();

        write_kind(KIND_F32);
        send_word(mk(64'hFFFF_FFFF_7FC0_0001, 0, 1, 0, 0), 0, '0);
        send_word(mk(64'h0000_0000_FF80_0001, 0, 2, 0, 0), 0, '0);
        send_word(mk(64'h1234_0000_8000_0000, 0, 3, 0, 0), 0, '0);
        send_word(mk(64'h0, 0, 4, 0, 0), 0, '0);
        send_word(mk(64'h7F80_0000, 0, 5, 0, 1), 0, '0);
        drain();
        write_kind(KIND_F64);
        send_word(mk(64'h7FF0_0000_0000_0001, 0, 1, 0, 0), 0, '0);
        send_word(mk(64'hFFFF_FFFF_FFFF_FFFF, 0, 2, 0, 0), 0, '0);
        send_word(mk(64'h8000_0000_0000_0000, 0, 3, 0, 0), 0, '0);
        send_word(mk(64'h0, 0, 4, 0, 1), 0, '0);
        drain();
        write_kind(2'd3);
        send_word(mk(64'h8000_0000_0000_0000, 0, 1, 0, 0), 0, '0);
        send_word(mk(64'h0, 0, 2, 0, 1), 0, '0);
        drain();

        // random arrays per value kind
        n = 0;
        for (int ph = 0; ph < 4; ph++) begin
            k = 2'(ph);
            write_kind(k);
            quiet = (ph == 1);
            if (ph == 2) fork
                begin
                    hold_off = 1;
                    repeat (400) @(negedge i_clk);
                    hold_off = 0;
                end
            join_none
            while (n < (ph + 1) * 390) begin
                if ($urandom_range(15) == 0) begin
                    send_word(mk({$urandom, $urandom}, 1'($urandom), 31'($urandom), 1,
                                 1'($urandom)), 0, '0);
                    n++;
                    continue;
                end
                len = $urandom_range(1, 12);
                for (int j = 0; j < len; j++) begin
                    send_word(rnd_elem(k, $urandom_range(3, 12), j == len - 1), 0, '0);
                    n++;
                end
            end
            quiet = 0;
            drain();
        end

        // one array past the set size, to reach overflow
        write_kind(KIND_INT);
        quiet = 1;
        for (int j = 0; j < 270; j++)
            send_word(mk(64'(j % 262), 0, 31'(j), 0, j == 269), 0, '0);
        quiet = 0;
        drain();

        finished = 1;
        $display("Covered %0d results, %0d overflow flags, all value kinds incl. unused code",
                 results, overflows);
        $display("with nulls, empty markers, NaN and signed-zero cases and a long stall.");
        if (errors == 0 && pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
